>>> rtl/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared types and constants for the retransmit tracking table.
// ----------------------------------------------------------------------------
package rtt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int SEQ_W   = 32;
  localparam int HDL_W   = 16;
  localparam int TIME_W  = 32;
  localparam int ATT_W   = 8;
  localparam int CLI_W   = 16;
  localparam int IVL_W   = 16;
  localparam int IN_W    = SEQ_W + HDL_W + TIME_W;          // 80
  localparam int OUT_W   = SEQ_W + HDL_W + CLI_W + ATT_W;   // 72

  // configuration register indexes
  localparam logic [1:0] CFG_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_MAX_ATT  = 2'd1;
  localparam logic [1:0] CFG_CLIENT   = 2'd2;

  localparam logic [IVL_W-1:0] INTERVAL_RST = 16'd100;
  localparam logic [ATT_W-1:0] MAX_ATT_RST  = 8'd5;
  localparam logic [CLI_W-1:0] CLIENT_RST   = 16'd0;

  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_ACK  = 2'd1,
    REQ_SCAN = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    KIND_RESEND    = 3'd0,
    KIND_DROPPED   = 3'd1,
    KIND_ADDED     = 3'd2,
    KIND_FULL      = 3'd3,
    KIND_ACKED     = 3'd4,
    KIND_UNKNOWN   = 3'd5,
    KIND_SCAN_DONE = 3'd6,
    KIND_SPARE     = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [HDL_W-1:0]  handle;
    logic [ATT_W-1:0]  count;
    logic [TIME_W-1:0] sent;
  } slot_t;

  typedef struct packed {
    logic             latch;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             eval_fire;
    logic [IDX_W-1:0] eval_idx;
    logic             finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic emit_need;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/retransmit_tracking_table.sv
// ----------------------------------------------------------------------------
// retransmit_tracking_table
// Table of unacknowledged packets with add, acknowledge and resend scan.
// ----------------------------------------------------------------------------
// Requests come in on the s_ stream: tuser carries the request type (add,
// acknowledge, scan), tdata the sequence number, buffer handle and time.
// Results leave on the m_ stream: tuser is the result kind, tlast marks the
// final beat caused by a request. An add or acknowledge gives one beat; a
// scan gives one beat per resent or dropped entry, then a scan-done beat.
// Config writes (interval, retry limit, client id) use the cfg_ channel and
// are always accepted.
// Every add, acknowledge or scan request sweeps all TABLE_DEPTH slots through
// the single read port of the slot memory, one slot a cycle while no waiting
// beat is held off by the receiver; a new request is taken only once the
// closing beat has been loaded. A request type of 3 is taken and ignored.
// While a beat waits with m_tready low the sweep stops at the next entry that would emit,
// and resumes without loss. Reset empties the table (valid bits cleared at
// once) and restores the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module retransmit_tracking_table
  import rtt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // config write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  // requests
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // seq_number[31:0], buffer_handle[47:32], now_time[79:48]
  input  logic [1:0]        s_tuser,   // req_type[1:0]
  // results
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // out_seq[31:0], out_handle[47:32], dest_client[63:48],
                                       // attempt_count[71:64]
  output logic [2:0]        m_tuser,   // kind[2:0]
  output logic              m_tlast    // last_of_run
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  rtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .in_req   (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rtt_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // an evaluated slot never overruns a held beat
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.eval_fire |-> !(stat.emit_need && !stat.out_free))
    else $error("slot evaluated while its beat could not be taken");

  // no table reads while waiting for a request
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !cmd.rd_en && !cmd.eval_fire)
    else $error("table access while idle");

  // mid-scan beats are never last, closing beats always are
  a_resend_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_RESEND || m_tuser == KIND_DROPPED) |-> !m_tlast)
    else $error("resend or drop beat marked last");

  a_close_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !(m_tuser == KIND_RESEND || m_tuser == KIND_DROPPED) |-> m_tlast)
    else $error("closing beat not marked last");

  // destination only on resend beats
  a_dest_resend: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != KIND_RESEND) |-> (m_tdata[63:48] == '0))
    else $error("destination set on a non-resend beat");

endmodule

>>> rtl/rtt_ctrl.sv
// ----------------------------------------------------------------------------
// rtt_ctrl
// Sequencer: takes a request, sweeps the slots through the read port of the
// table, then issues the closing beat.
// ----------------------------------------------------------------------------
module rtt_ctrl
  import rtt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic [1:0] in_req,
  output logic       s_tready,
  input  dp_stat_t   stat,
  output ctl_cmd_t   cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] rd_cnt;
  logic             e_vld;
  logic [IDX_W-1:0] e_idx;
  logic             adv;
  logic             issue;

  // eval stage holds while its beat cannot go out
  assign adv   = !(e_vld && stat.emit_need && !stat.out_free);
  assign issue = (rd_cnt != CNT_W'(TABLE_DEPTH));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && (req_t'(in_req) != REQ_NONE)) state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (!issue && adv) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = (state == ST_IDLE);
    cmd.latch     = (state == ST_IDLE) && s_tvalid;
    cmd.rd_en     = (state == ST_SWEEP) && adv && issue;
    cmd.rd_addr   = rd_cnt[IDX_W-1:0];
    cmd.eval_fire = (state == ST_SWEEP) && e_vld && adv;
    cmd.eval_idx  = e_idx;
    cmd.finish    = (state == ST_FINISH) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd_cnt <= '0;
      e_vld  <= 1'b0;
      e_idx  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        rd_cnt <= '0;
        e_vld  <= 1'b0;
      end else if ((state == ST_SWEEP) && adv) begin
        if (issue) rd_cnt <= rd_cnt + CNT_W'(1);
        e_vld <= issue;
        e_idx <= rd_cnt[IDX_W-1:0];
      end
    end
  end

endmodule

>>> rtl/rtt_dpath.sv
// ----------------------------------------------------------------------------
// rtt_dpath
// Slot memory, valid bits, request and config registers, match tracking and
// the output register.
// ----------------------------------------------------------------------------
module rtt_dpath
  import rtt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic [IN_W-1:0]   s_tdata,
  input  logic [1:0]        s_tuser,
  input  ctl_cmd_t          cmd,
  output dp_stat_t          stat,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [OUT_W-1:0]  m_tdata,
  output logic [2:0]        m_tuser,
  output logic              m_tlast
);

  logic [IVL_W-1:0] interval;
  logic [ATT_W-1:0] max_att;
  logic [CLI_W-1:0] client;

  req_t              req;
  logic [SEQ_W-1:0]  req_seq;
  logic [HDL_W-1:0]  req_handle;
  logic [TIME_W-1:0] req_now;

  slot_t            mem [TABLE_DEPTH];
  slot_t            rd_q;
  logic [TABLE_DEPTH-1:0] slot_valid;

  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [HDL_W-1:0] hit_handle;
  logic [ATT_W-1:0] hit_count;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic              cur_valid;
  logic [TIME_W-1:0] elapsed;
  logic              due;
  logic              drop;
  logic [ATT_W-1:0]  count_inc;
  logic              scan_emit;
  logic              add_ok;
  logic [IDX_W-1:0]  add_idx;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  slot_t             wr_data;

  logic              out_load;
  kind_t             out_kind, out_kind_next;
  logic [SEQ_W-1:0]  out_seq, out_seq_next;
  logic [HDL_W-1:0]  out_handle, out_handle_next;
  logic [CLI_W-1:0]  out_client, out_client_next;
  logic [ATT_W-1:0]  out_count, out_count_next;
  logic              out_last, out_last_next;

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= INTERVAL_RST;
      max_att  <= MAX_ATT_RST;
      client   <= CLIENT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INTERVAL: interval <= cfg_data;
        CFG_MAX_ATT:  max_att  <= cfg_data[ATT_W-1:0];
        CFG_CLIENT:   client   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req        <= req_t'(s_tuser);
      req_seq    <= s_tdata[SEQ_W-1:0];
      req_handle <= s_tdata[SEQ_W+HDL_W-1:SEQ_W];
      req_now    <= s_tdata[IN_W-1:SEQ_W+HDL_W];
    end
  end

  // per-slot evaluation
  assign cur_valid = slot_valid[cmd.eval_idx];
  assign elapsed   = req_now - rd_q.sent;
  assign due       = (elapsed >= {{(TIME_W-IVL_W){1'b0}}, interval});
  assign drop      = (rd_q.count >= max_att);
  assign count_inc = rd_q.count + ATT_W'(1);
  assign scan_emit = (req == REQ_SCAN) && cur_valid && due;
  assign add_ok    = hit || free_found;
  assign add_idx   = hit ? hit_idx : free_idx;

  assign stat.emit_need = scan_emit;
  assign stat.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.latch) begin
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.eval_fire) begin
      if (cur_valid && (rd_q.seq == req_seq) && !hit) hit <= 1'b1;
      if (!cur_valid && !free_found) free_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_fire) begin
      if (cur_valid && (rd_q.seq == req_seq) && !hit) begin
        hit_idx    <= cmd.eval_idx;
        hit_handle <= rd_q.handle;
        hit_count  <= rd_q.count;
      end
      if (!cur_valid && !free_found) free_idx <= cmd.eval_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else begin
      if (cmd.eval_fire && scan_emit && drop) slot_valid[cmd.eval_idx] <= 1'b0;
      if (cmd.finish) begin
        if ((req == REQ_ADD) && add_ok) slot_valid[add_idx] <= 1'b1;
        if ((req == REQ_ACK) && hit) slot_valid[hit_idx] <= 1'b0;
      end
    end
  end

  // table write port: resend update during a scan, new entry on an add
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmd.eval_idx;
    wr_data = '{seq: rd_q.seq, handle: rd_q.handle, count: count_inc, sent: req_now};
    if (cmd.eval_fire && scan_emit && !drop) begin
      wr_en = 1'b1;
    end else if (cmd.finish && (req == REQ_ADD) && add_ok) begin
      wr_en   = 1'b1;
      wr_addr = add_idx;
      wr_data = '{seq: req_seq, handle: req_handle, count: '0, sent: req_now};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_q <= mem[cmd.rd_addr];
  end

  // result beat
  always_comb begin
    out_load        = 1'b0;
    out_kind_next   = KIND_SCAN_DONE;
    out_seq_next    = '0;
    out_handle_next = '0;
    out_client_next = '0;
    out_count_next  = '0;
    out_last_next   = 1'b0;
    if (cmd.eval_fire && scan_emit) begin
      out_load        = 1'b1;
      out_seq_next    = rd_q.seq;
      out_handle_next = rd_q.handle;
      if (drop) begin
        out_kind_next  = KIND_DROPPED;
        out_count_next = rd_q.count;
      end else begin
        out_kind_next   = KIND_RESEND;
        out_client_next = client;
        out_count_next  = count_inc;
      end
    end else if (cmd.finish) begin
      out_load      = 1'b1;
      out_last_next = 1'b1;
      case (req)
        REQ_ADD: begin
          out_kind_next   = add_ok ? KIND_ADDED : KIND_FULL;
          out_seq_next    = req_seq;
          out_handle_next = req_handle;
        end
        REQ_ACK: begin
          out_seq_next = req_seq;
          if (hit) begin
            out_kind_next   = KIND_ACKED;
            out_handle_next = hit_handle;
            out_count_next  = hit_count;
          end else begin
            out_kind_next = KIND_UNKNOWN;
          end
        end
        default: out_kind_next = KIND_SCAN_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind   <= out_kind_next;
      out_seq    <= out_seq_next;
      out_handle <= out_handle_next;
      out_client <= out_client_next;
      out_count  <= out_count_next;
      out_last   <= out_last_next;
    end
  end

  assign m_tdata = {out_count, out_client, out_handle, out_seq};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule
